// ===== src/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Box filter downscaler package
// Sizes, accumulator entry layout, divider request and response, FSM codes.
// ----------------------------------------------------------------------------
`default_nettype none
package bfd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    localparam int DIM_W      = 13;
    localparam int PIX_W      = 8;
    localparam int POS_W      = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    localparam int AREA_W     = 2 * DIM_W;
    localparam int ASUM_W     = 32;
    localparam int CSUM_W     = 40;

    localparam int DIV_NUM_W  = CSUM_W + 1;
    localparam int DIV_DEN_W  = ASUM_W + 1;
    localparam int DIV_Q_W    = DIM_W;
    localparam int DIV_SH_W   = 48;
    localparam int STEP_W     = $clog2(DIM_W + 1);

    localparam logic [STEP_W-1:0] STEPS_PIX  = STEP_W'(PIX_W);
    localparam logic [STEP_W-1:0] STEPS_EDGE = STEP_W'(DIM_W);

    localparam int CFG_ADDR_W = 4;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_WIDTH  = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_HEIGHT = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_WIDTH  = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_HEIGHT = 4'd3;

    typedef struct packed {
        logic [ASUM_W-1:0] alpha;
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } acc_entry_t;

    typedef struct packed {
        logic                 start;
        logic [STEP_W-1:0]    steps;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ADV,
        ST_EDGE_START,
        ST_EDGE_WAIT,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        TGT_COL,
        TGT_ROW,
        TGT_COL1,
        TGT_ROW1
    } edge_tgt_t;

endpackage
`default_nettype wire

// ===== src/bfd_div.sv =====
// ----------------------------------------------------------------------------
// Box filter downscaler divider
// Restoring divider producing one quotient bit per cycle, quotient known to
// fit in the requested number of steps.
// ----------------------------------------------------------------------------
`default_nettype none
module bfd_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bfd_pkg::div_req_t req,
    output bfd_pkg::div_rsp_t      rsp
);
    import bfd_pkg::*;

    logic [DIV_NUM_W-1:0] rem_reg;
    logic [DIV_SH_W-1:0]  dsh_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic [STEP_W-1:0]    cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic                 ge;

    assign ge = DIV_SH_W'(rem_reg) >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
                cnt_reg <= req.steps;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.num;
            dsh_reg <= DIV_SH_W'(req.den) << (req.steps - STEP_W'(1));
            quo_reg <= '0;
        end else if (run_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - DIV_NUM_W'(dsh_reg);
            end
            quo_reg <= {quo_reg[DIV_Q_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule
`default_nettype wire

// ===== src/box_filter_image_downscaler_top.sv =====
// ----------------------------------------------------------------------------
// Box filter image downscaler
// Area-averages RGBA source pixels into boxes and emits one pixel per box.
// ----------------------------------------------------------------------------
// A new source pixel is accepted only once the previous one is finished; pixels
// where a box edge is recomputed, and the pixel that completes a box, take longer;
// the shared bit-serial divider behind the accumulator memory sets this.
// A box result is held back while the previous result is still held by the receiver.
// Reset: synchronous; sizes return to 1, the accumulator memory is not cleared.
`default_nettype none
module box_filter_image_downscaler_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    input  wire logic [31:0]                    s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // red [7:0], green [15:8], blue [23:16], alpha [31:24]
    output logic [31:0]                         m_tdata,
    output logic                                m_tlast,
    // frame_end [0]
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_we,
    input  wire logic [bfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [bfd_pkg::DIM_W-1:0]      cfg_wdata
);
    import bfd_pkg::*;

    state_t    state_reg, state_next;
    edge_tgt_t tgt_reg;

    logic [DIM_W-1:0] src_w_reg, src_h_reg, out_w_reg, out_h_reg;
    logic [COL_W-1:0] src_col_reg, oc_reg;
    logic [ROW_W-1:0] src_row_reg, or_reg;
    logic [DIM_W-1:0] col_edge_reg, row_edge_reg, left_reg, top_reg;
    logic [DIM_W-1:0] col_edge1_reg, row_edge1_reg;

    logic [PIX_W-1:0]  pr_reg, pg_reg, pb_reg, pa_reg;
    logic [ASUM_W-1:0] sa_reg;
    logic [CSUM_W-1:0] sr_reg, sg_reg, sb_reg;
    logic [AREA_W-1:0] n_reg;
    logic              done_reg, last_col_reg, last_row_reg;
    logic [1:0]        div_sel_reg;
    logic [PIX_W-1:0]  qr_reg, qg_reg, qb_reg, qa_reg;

    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;
    logic              m_tlast_reg, m_tuser_reg;

    acc_entry_t mem [MAX_WIDTH];
    acc_entry_t rd_reg;
    acc_entry_t acc_new;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic sizes_ok, cfg_hit, s_accept, out_free, emit;
    logic first, col_hit, row_hit, wrap, fwrap, need_edge;
    logic [POS_W-1:0] edge_idx;
    logic [DIM_W-1:0] edge_src, edge_out;

    assign sizes_ok = (src_w_reg >= DIM_W'(1)) && (POS_W'(src_w_reg) <= POS_W'(MAX_WIDTH)) &&
                      (src_h_reg >= DIM_W'(1)) && (POS_W'(src_h_reg) <= POS_W'(MAX_HEIGHT)) &&
                      (out_w_reg >= DIM_W'(1)) && (out_w_reg <= src_w_reg) &&
                      (out_h_reg >= DIM_W'(1)) && (out_h_reg <= src_h_reg);
    assign cfg_hit  = cfg_we && (cfg_addr <= REG_OUT_HEIGHT);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    // A finished box moves into the output register only once it is free.
    assign emit     = (state_reg == ST_FIN) && done_reg && out_free && !cfg_hit;

    assign first   = (POS_W'(src_col_reg) == POS_W'(left_reg)) &&
                     (POS_W'(src_row_reg) == POS_W'(top_reg));
    assign col_hit = (POS_W'(src_col_reg) + POS_W'(1)) == POS_W'(col_edge_reg);
    assign row_hit = (POS_W'(src_row_reg) + POS_W'(1)) == POS_W'(row_edge_reg);
    assign wrap    = (POS_W'(src_col_reg) + POS_W'(1)) >= POS_W'(src_w_reg);
    assign fwrap   = (POS_W'(src_row_reg) + POS_W'(1)) >= POS_W'(src_h_reg);
    assign need_edge = wrap ? (!fwrap && row_hit) : col_hit;

    // A box's first pixel overwrites the column entry instead of adding to it.
    always_comb begin
        acc_new.alpha = first ? ASUM_W'(pa_reg) : rd_reg.alpha + ASUM_W'(pa_reg);
        acc_new.red   = (first ? '0 : rd_reg.red)   + CSUM_W'(16'(pr_reg) * 16'(pa_reg));
        acc_new.green = (first ? '0 : rd_reg.green) + CSUM_W'(16'(pg_reg) * 16'(pa_reg));
        acc_new.blue  = (first ? '0 : rd_reg.blue)  + CSUM_W'(16'(pb_reg) * 16'(pa_reg));
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ACC) begin
            mem[oc_reg] <= acc_new;
        end
        if (s_accept && sizes_ok) begin
            rd_reg <= mem[oc_reg];
        end
    end

    always_comb begin
        unique case (tgt_reg)
            TGT_COL:  edge_idx = POS_W'(oc_reg) + POS_W'(1);
            TGT_ROW:  edge_idx = POS_W'(or_reg) + POS_W'(1);
            default:  edge_idx = POS_W'(1);
        endcase
        if (tgt_reg == TGT_COL || tgt_reg == TGT_COL1) begin
            edge_src = src_w_reg;
            edge_out = out_w_reg;
        end else begin
            edge_src = src_h_reg;
            edge_out = out_h_reg;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_accept && sizes_ok) state_next = ST_ACC;
            ST_ACC:        state_next = (col_hit && row_hit) ? ST_DIV_START : ST_ADV;
            ST_DIV_START:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (div_sel_reg == 2'd3) ? ST_ADV : ST_DIV_START;
                end
            end
            ST_ADV:        state_next = need_edge ? ST_EDGE_START : ST_FIN;
            ST_EDGE_START: state_next = ST_EDGE_WAIT;
            ST_EDGE_WAIT: begin
                if (div_rsp.done) begin
                    unique case (tgt_reg)
                        TGT_COL1: state_next = ST_EDGE_START;
                        TGT_ROW1: state_next = ST_IDLE;
                        default:  state_next = ST_FIN;
                    endcase
                end
            end
            ST_FIN:        if (!done_reg || out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
        if (cfg_hit) begin
            state_next = ST_EDGE_START;
        end
    end

    // Outputs of the state machine
    always_comb begin
        s_tready      = (state_reg == ST_IDLE) && !cfg_hit;
        div_req.start = 1'b0;
        div_req.steps = STEPS_PIX;
        div_req.num   = '0;
        div_req.den   = '0;
        if (state_reg == ST_DIV_START) begin
            div_req.start = 1'b1;
            unique case (div_sel_reg)
                2'd0:    div_req.num = DIV_NUM_W'(sr_reg) + DIV_NUM_W'(sa_reg >> 1);
                2'd1:    div_req.num = DIV_NUM_W'(sg_reg) + DIV_NUM_W'(sa_reg >> 1);
                2'd2:    div_req.num = DIV_NUM_W'(sb_reg) + DIV_NUM_W'(sa_reg >> 1);
                default: div_req.num = DIV_NUM_W'(sa_reg) + DIV_NUM_W'(n_reg >> 1);
            endcase
            div_req.den = (div_sel_reg == 2'd3) ? DIV_DEN_W'(n_reg) : DIV_DEN_W'(sa_reg);
        end else if (state_reg == ST_EDGE_START) begin
            div_req.start = 1'b1;
            div_req.steps = STEPS_EDGE;
            div_req.num   = DIV_NUM_W'(AREA_W'(edge_idx) * AREA_W'(edge_src));
            div_req.den   = DIV_DEN_W'(edge_out);
        end
    end

    bfd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Control and position state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tgt_reg       <= TGT_COL;
            src_w_reg     <= DIM_W'(1);
            src_h_reg     <= DIM_W'(1);
            out_w_reg     <= DIM_W'(1);
            out_h_reg     <= DIM_W'(1);
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            oc_reg        <= '0;
            or_reg        <= '0;
            left_reg      <= '0;
            top_reg       <= '0;
            col_edge_reg  <= DIM_W'(1);
            row_edge_reg  <= DIM_W'(1);
            col_edge1_reg <= DIM_W'(1);
            row_edge1_reg <= DIM_W'(1);
            div_sel_reg   <= '0;
            done_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_hit) begin
                unique case (cfg_addr)
                    REG_SRC_WIDTH:  src_w_reg <= cfg_wdata;
                    REG_SRC_HEIGHT: src_h_reg <= cfg_wdata;
                    REG_OUT_WIDTH:  out_w_reg <= cfg_wdata;
                    default:        out_h_reg <= cfg_wdata;
                endcase
                src_col_reg <= '0;
                src_row_reg <= '0;
                oc_reg      <= '0;
                or_reg      <= '0;
                left_reg    <= '0;
                top_reg     <= '0;
                tgt_reg     <= TGT_COL1;
                done_reg    <= 1'b0;
            end else begin
                unique case (state_reg)
                    ST_ACC: begin
                        done_reg    <= col_hit && row_hit;
                        div_sel_reg <= '0;
                    end
                    ST_DIV_WAIT: begin
                        if (div_rsp.done) begin
                            div_sel_reg <= div_sel_reg + 2'd1;
                        end
                    end
                    ST_ADV: begin
                        if (wrap) begin
                            src_col_reg  <= '0;
                            oc_reg       <= '0;
                            left_reg     <= '0;
                            col_edge_reg <= col_edge1_reg;
                            if (fwrap) begin
                                src_row_reg  <= '0;
                                or_reg       <= '0;
                                top_reg      <= '0;
                                row_edge_reg <= row_edge1_reg;
                            end else begin
                                src_row_reg <= src_row_reg + ROW_W'(1);
                                if (row_hit) begin
                                    or_reg  <= or_reg + ROW_W'(1);
                                    top_reg <= row_edge_reg;
                                    tgt_reg <= TGT_ROW;
                                end
                            end
                        end else begin
                            src_col_reg <= src_col_reg + COL_W'(1);
                            if (col_hit) begin
                                oc_reg   <= oc_reg + COL_W'(1);
                                left_reg <= col_edge_reg;
                                tgt_reg  <= TGT_COL;
                            end
                        end
                    end
                    ST_EDGE_WAIT: begin
                        if (div_rsp.done) begin
                            unique case (tgt_reg)
                                TGT_COL:  col_edge_reg <= div_rsp.quo;
                                TGT_ROW:  row_edge_reg <= div_rsp.quo;
                                TGT_COL1: begin
                                    col_edge1_reg <= div_rsp.quo;
                                    tgt_reg       <= TGT_ROW1;
                                end
                                default: begin
                                    row_edge1_reg <= div_rsp.quo;
                                    row_edge_reg  <= div_rsp.quo;
                                    col_edge_reg  <= col_edge1_reg;
                                end
                            endcase
                        end
                    end
                    ST_FIN: begin
                        if (done_reg && out_free) begin
                            done_reg <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pr_reg <= s_tdata[7:0];
            pg_reg <= s_tdata[15:8];
            pb_reg <= s_tdata[23:16];
            pa_reg <= s_tdata[31:24];
        end
        if (state_reg == ST_ACC) begin
            sa_reg       <= acc_new.alpha;
            sr_reg       <= acc_new.red;
            sg_reg       <= acc_new.green;
            sb_reg       <= acc_new.blue;
            n_reg        <= AREA_W'(col_edge_reg - left_reg) * AREA_W'(row_edge_reg - top_reg);
            last_col_reg <= (POS_W'(oc_reg) + POS_W'(1)) == POS_W'(out_w_reg);
            last_row_reg <= (POS_W'(or_reg) + POS_W'(1)) == POS_W'(out_h_reg);
        end
        if (state_reg == ST_DIV_WAIT && div_rsp.done) begin
            unique case (div_sel_reg)
                2'd0:    qr_reg <= div_rsp.quo[PIX_W-1:0];
                2'd1:    qg_reg <= div_rsp.quo[PIX_W-1:0];
                2'd2:    qb_reg <= div_rsp.quo[PIX_W-1:0];
                default: qa_reg <= div_rsp.quo[PIX_W-1:0];
            endcase
        end
        if (emit) begin
            if (sa_reg == '0) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {qa_reg, qb_reg, qg_reg, qr_reg};
            end
            m_tlast_reg <= last_col_reg;
            m_tuser_reg <= last_col_reg && last_row_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

// ===== src/bfd_chk.sv =====
// ----------------------------------------------------------------------------
// Box filter downscaler checker
// Port-level properties of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module bfd_chk (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic [31:0]                    m_tdata,
    input wire logic                           m_tlast,
    input wire logic                           m_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic                           cfg_we,
    input wire logic [bfd_pkg::CFG_ADDR_W-1:0] cfg_addr
);
    import bfd_pkg::*;

    // A held beat stays valid.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A held beat keeps its payload.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The last pixel of the image also closes its row.
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without row end");

    // A register write restarts the frame and recomputes the edges first.
    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_addr <= REG_OUT_HEIGHT) |=> !s_tready)
        else $error("input accepted while edges are recomputed");

endmodule

bind box_filter_image_downscaler_top bfd_chk u_bfd_chk (.*);
`default_nettype wire
